// ===== rtl/pdst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdst_pkg
// Shared types, widths and reset values for the proximity dwell spray trigger.
// ----------------------------------------------------------------------------
package pdst_pkg;

    localparam int DIST_W     = 10;
    localparam int THR_W      = 7;
    localparam int TIME_W     = 16;
    localparam int SUM_W      = 16;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int CAL_SAMPLES_DEF = 30;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd3;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = 7'd90;
    localparam logic [TIME_W-1:0] DWELL_RST     = 16'd2000;
    localparam logic [TIME_W-1:0] INTERVAL_RST  = 16'd200;
    localparam logic [TIME_W-1:0] COOLDOWN_RST  = 16'd10000;

    typedef struct packed {
        logic [THR_W-1:0]  threshold_percent;
        logic [TIME_W-1:0] dwell_ms;
        logic [TIME_W-1:0] read_interval_ms;
        logic [TIME_W-1:0] cooldown_ms;
    } pdst_cfg_t;

    typedef struct packed {
        logic              motor_run;
        logic              presence_led;
        logic              calibrating;
        logic [DIST_W-1:0] reference_distance;
    } pdst_result_t;

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        sat_inc = (v == '1) ? v : v + TIME_W'(1);
    endfunction

endpackage : pdst_pkg
`default_nettype wire

// ===== rtl/pdst_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdst_engine
// Tick state: calibration, dwell tracking and spray sequencing. Advances one
// tick on step and presents that tick's result combinationally.
// ----------------------------------------------------------------------------
module pdst_engine #(
    parameter int CAL_SAMPLES = pdst_pkg::CAL_SAMPLES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [pdst_pkg::DIST_W-1:0] distance,
    input  wire logic                      switch_level,
    input  wire pdst_pkg::pdst_cfg_t       cfg,
    output pdst_pkg::pdst_result_t         result
);
    import pdst_pkg::*;

    typedef enum logic [1:0] {
        PH_CAL,
        PH_WATCH,
        PH_SPRAY
    } phase_t;

    // Exact divide of a 16-bit sum by CAL_SAMPLES: ceil(2^22 / d) reciprocal,
    // exact for any dividend below 2^16 while d stays below 64.
    localparam int RECIP_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [CNT_W-1:0] CAL_TARGET = CNT_W'(CAL_SAMPLES);
    localparam int PRES_W = DIST_W + THR_W;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DIST_W-1:0] ref_reg, ref_next;
    logic [TIME_W-1:0] read_el_reg, read_el_next;
    logic [TIME_W-1:0] cool_el_reg, cool_el_next;
    logic              dwell_on_reg, dwell_on_next;
    logic [TIME_W-1:0] dwell_el_reg, dwell_el_next;
    logic              sw_high_reg, sw_high_next;

    logic              read_due;
    logic              cool_over;
    logic              dist_nz;
    logic              presence;
    logic [SUM_W-1:0]  sum_add;
    logic [PROD_W-1:0] quot_prod;
    logic [PRES_W-1:0] dist_scaled;
    logic [PRES_W-1:0] ref_scaled;

    assign read_due    = read_el_reg >= cfg.read_interval_ms;
    assign cool_over   = cool_el_reg >= cfg.cooldown_ms;
    assign dist_nz     = distance != '0;
    assign dist_scaled = PRES_W'(distance) * PRES_W'(100);
    assign ref_scaled  = PRES_W'(ref_reg) * PRES_W'(cfg.threshold_percent);
    assign presence    = dist_nz && (dist_scaled < ref_scaled);
    assign sum_add     = sum_reg + SUM_W'(distance);
    assign quot_prod   = PROD_W'(sum_add) * PROD_W'(RECIP);

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        ref_next      = ref_reg;
        read_el_next  = sat_inc(read_el_reg);
        cool_el_next  = sat_inc(cool_el_reg);
        dwell_on_next = dwell_on_reg;
        dwell_el_next = dwell_on_reg ? sat_inc(dwell_el_reg) : dwell_el_reg;
        sw_high_next  = sw_high_reg;

        case (phase_reg)
            PH_CAL:
            begin
                // Calibration ignores the cooldown; a zero read still uses the slot
                if (read_due)
                begin
                    read_el_next = '0;
                    if (dist_nz)
                    begin
                        sum_next   = sum_add;
                        count_next = count_reg + CNT_W'(1);
                        if (count_next >= CAL_TARGET)
                        begin
                            ref_next   = quot_prod[RECIP_SHIFT +: DIST_W];
                            phase_next = PH_WATCH;
                        end
                    end
                end
            end
            PH_WATCH:
            begin
                if (read_due && cool_over)
                begin
                    read_el_next = '0;
                    if (presence)
                    begin
                        if (!dwell_on_reg)
                        begin
                            dwell_on_next = 1'b1;
                            dwell_el_next = '0;
                        end
                        else if (dwell_el_next >= cfg.dwell_ms)
                        begin
                            phase_next = PH_SPRAY;
                        end
                    end
                    else
                    begin
                        dwell_on_next = 1'b0;
                        dwell_el_next = '0;
                    end
                end
            end
            PH_SPRAY:
            begin
                // Spray ends once the switch has gone high and then low
                if (!sw_high_reg && switch_level)
                begin
                    sw_high_next = 1'b1;
                end
                else if (sw_high_reg && !switch_level)
                begin
                    sw_high_next  = 1'b0;
                    cool_el_next  = '0;
                    dwell_on_next = 1'b0;
                    dwell_el_next = '0;
                    phase_next    = PH_WATCH;
                end
            end
            default:
            begin
                phase_next = PH_CAL;
            end
        endcase
    end

    assign result.motor_run          = phase_reg == PH_SPRAY;
    assign result.presence_led       = dwell_on_next;
    assign result.calibrating        = phase_next == PH_CAL;
    assign result.reference_distance = ref_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CAL;
            count_reg    <= '0;
            sum_reg      <= '0;
            ref_reg      <= '0;
            read_el_reg  <= '0;
            cool_el_reg  <= '0;
            dwell_on_reg <= 1'b0;
            dwell_el_reg <= '0;
            sw_high_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            ref_reg      <= ref_next;
            read_el_reg  <= read_el_next;
            cool_el_reg  <= cool_el_next;
            dwell_on_reg <= dwell_on_next;
            dwell_el_reg <= dwell_el_next;
            sw_high_reg  <= sw_high_next;
        end
    end

endmodule : pdst_engine
`default_nettype wire

// ===== rtl/proximity_dwell_spray_trigger_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// proximity_dwell_spray_trigger_core
// Millisecond-tick presence detector that calibrates a reference distance,
// tracks a dwell and drives the spray motor until the cap switch cycles.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick and yields exactly one result
// transaction. The block takes a tick every clock cycle while the result stage
// drains; a tick's result passes through the input register, then the result
// register, and while a result waits for out_ready the input side accepts a
// tick only into an empty input register. Configuration writes (index 0 threshold
// percent, 1 dwell, 2 read interval, 3 cooldown; low bits kept) are always
// accepted and must only be issued while the block is idle.
module proximity_dwell_spray_trigger_core #(
    parameter int CAL_SAMPLES = pdst_pkg::CAL_SAMPLES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [pdst_pkg::DIST_W-1:0]     distance,
    input  wire logic                            switch_level,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 motor_run,
    output logic                                 presence_led,
    output logic                                 calibrating,
    output logic [pdst_pkg::DIST_W-1:0]          reference_distance,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pdst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pdst_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pdst_pkg::*;

    pdst_cfg_t         cfg_reg;
    logic              in_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              sw_reg;
    logic              out_valid_reg;
    pdst_result_t      result_reg;
    pdst_result_t      result_next;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_percent <= THRESHOLD_RST;
            cfg_reg.dwell_ms          <= DWELL_RST;
            cfg_reg.read_interval_ms  <= INTERVAL_RST;
            cfg_reg.cooldown_ms       <= COOLDOWN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD: cfg_reg.threshold_percent <= cfg_data[THR_W-1:0];
                REG_DWELL:     cfg_reg.dwell_ms          <= cfg_data[TIME_W-1:0];
                REG_INTERVAL:  cfg_reg.read_interval_ms  <= cfg_data[TIME_W-1:0];
                REG_COOLDOWN:  cfg_reg.cooldown_ms       <= cfg_data[TIME_W-1:0];
                default:       cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dist_reg <= distance;
            sw_reg   <= switch_level;
        end
    end

    pdst_engine #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .distance     (dist_reg),
        .switch_level (sw_reg),
        .cfg          (cfg_reg),
        .result       (result_next)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign motor_run          = result_reg.motor_run;
    assign presence_led       = result_reg.presence_led;
    assign calibrating        = result_reg.calibrating;
    assign reference_distance = result_reg.reference_distance;

endmodule : proximity_dwell_spray_trigger_core
`default_nettype wire
